[hdl/gbmd_pkg.sv]
// ----------------------------------------------------------------------------
// gbmd_pkg
// Types and constants shared by the glyph box max downscaler modules.
// ----------------------------------------------------------------------------
package gbmd_pkg;

  localparam int unsigned DIM_W = 10;
  localparam int unsigned PROD_W = 18;

  typedef enum logic [1:0] {
    CFG_GLYPH_WIDTH  = 2'd0,
    CFG_GLYPH_HEIGHT = 2'd1,
    CFG_SCALE_PCT    = 2'd2,
    CFG_TWO_BIT_MODE = 2'd3
  } cfg_idx_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  typedef struct packed {
    logic        func;
    logic [10:0] byte_addr;
    logic [7:0]  byte_data;
    logic [9:0]  out_col;
    logic [9:0]  out_row;
  } in_item_t;

  typedef struct packed {
    logic [1:0] raw_max;
    logic [1:0] inverted_level;
    logic [1:0] image_level;
    logic       ink;
    logic       in_range;
  } out_item_t;

  // queued command between front and back
  typedef struct packed {
    logic       in_range;
    logic [9:0] col;
    logic [9:0] row;
  } qcmd_t;

  function automatic logic [1:0] level_map(input logic [1:0] inv);
    logic [1:0] r;
    case (inv)
      2'd0:    r = 2'd3;
      2'd1:    r = 2'd1;
      2'd2:    r = 2'd2;
      default: r = 2'd0;
    endcase
    return r;
  endfunction

endpackage

[hdl/gbmd_divu.sv]
// ----------------------------------------------------------------------------
// gbmd_divu
// Restoring divider, one quotient bit per cycle, 18-bit by 10-bit.
// ----------------------------------------------------------------------------
module gbmd_divu (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          go,
  input  logic [gbmd_pkg::PROD_W-1:0]   num,
  input  logic [gbmd_pkg::DIM_W-1:0]    den,
  output logic                          done,
  output logic [gbmd_pkg::PROD_W-1:0]   quo
);
  localparam int unsigned NW = gbmd_pkg::PROD_W;
  localparam int unsigned DW = gbmd_pkg::DIM_W;

  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r, den_nxt;
  logic [4:0]    cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [DW+1:0] trial;

  always_comb begin
    q_nxt = q_r;
    rem_nxt = rem_r;
    den_nxt = den_r;
    cnt_nxt = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    trial = {rem_r, q_r[NW-1]} - {2'b00, den_r};
    if (go) begin
      q_nxt = num;
      rem_nxt = '0;
      den_nxt = den;
      cnt_nxt = 5'(NW);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[DW+1]) begin
        rem_nxt = trial[DW:0];
        q_nxt = {q_r[NW-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[DW-1:0], q_r[NW-1]};
        q_nxt = {q_r[NW-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 5'd1;
      if (cnt_r == 5'd1) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
    q_r <= q_nxt;
    rem_r <= rem_nxt;
    den_r <= den_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
endmodule

[hdl/gbmd_front.sv]
// ----------------------------------------------------------------------------
// gbmd_front
// Configuration registers, scaled sizes, store writes and query classing.
// ----------------------------------------------------------------------------
module gbmd_front #(
  parameter int unsigned STORE_BYTES = 2048
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [1:0]           cfg_index,
  input  logic [7:0]           cfg_data,
  input  logic                 acc,
  input  gbmd_pkg::in_item_t   item,
  output logic [7:0]           gw,
  output logic [7:0]           gh,
  output logic                 two_bit,
  output logic [9:0]           sw,
  output logic [9:0]           sh,
  output logic                 wr_en,
  output logic [10:0]          wr_addr,
  output logic [7:0]           wr_data,
  output logic                 q_push,
  output gbmd_pkg::qcmd_t      q_cmd,
  output logic                 sz_busy
);
  logic [7:0]  gw_r, gh_r, pct_r;
  logic        tb_r;
  logic [9:0]  sw_r, sh_r;
  logic [1:0]  sz_cnt_r;
  logic [15:0] prod_r;
  logic [15:0] rnd;
  logic [28:0] recip;
  logic [9:0]  scaled;

  // (p + 50) / 100 as (((p + 50) >> 2) * 20972) >> 19, exact below 2^16
  assign rnd = prod_r + 16'd50;
  assign recip = 29'(rnd[15:2]) * 29'd20972;
  assign scaled = (recip[28:19] == 10'd0) ? 10'd1 : recip[28:19];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gw_r <= 8'd8; gh_r <= 8'd8; pct_r <= 8'd100; tb_r <= 1'b0;
      sw_r <= 10'd8; sh_r <= 10'd8; sz_cnt_r <= '0; prod_r <= '0;
    end else begin
      if (cfg_we) begin
        case (gbmd_pkg::cfg_idx_t'(cfg_index))
          gbmd_pkg::CFG_GLYPH_WIDTH:  gw_r <= cfg_data;
          gbmd_pkg::CFG_GLYPH_HEIGHT: gh_r <= cfg_data;
          gbmd_pkg::CFG_SCALE_PCT:    pct_r <= cfg_data;
          gbmd_pkg::CFG_TWO_BIT_MODE: tb_r <= cfg_data[0];
          default:                    tb_r <= tb_r;
        endcase
        sz_cnt_r <= 2'd1;
      end else begin
        case (sz_cnt_r)
          2'd1: begin
            prod_r <= 16'(gw_r) * 16'(pct_r);
            sz_cnt_r <= 2'd2;
          end
          2'd2: begin
            sw_r <= scaled;
            prod_r <= 16'(gh_r) * 16'(pct_r);
            sz_cnt_r <= 2'd3;
          end
          2'd3: begin
            sh_r <= scaled;
            sz_cnt_r <= 2'd0;
          end
          default: sz_cnt_r <= 2'd0;
        endcase
      end
    end
  end

  assign sz_busy = (sz_cnt_r != 2'd0);
  assign gw = gw_r;
  assign gh = gh_r;
  assign two_bit = tb_r;
  assign sw = sw_r;
  assign sh = sh_r;
  assign wr_en = acc && item.func == gbmd_pkg::FUNC_LOAD &&
                 ({6'd0, item.byte_addr} < 17'(STORE_BYTES));
  assign wr_addr = item.byte_addr;
  assign wr_data = item.byte_data;
  assign q_push = acc && item.func == gbmd_pkg::FUNC_QUERY;
  assign q_cmd.in_range = (item.out_col < sw_r) && (item.out_row < sh_r);
  assign q_cmd.col = item.out_col;
  assign q_cmd.row = item.out_row;
endmodule

[hdl/gbmd_back.sv]
// ----------------------------------------------------------------------------
// gbmd_back
// Box bounds by division, then a walk over the box reading the store.
// ----------------------------------------------------------------------------
module gbmd_back #(
  parameter int unsigned STORE_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic [7:0]          gw,
  input  logic [7:0]          gh,
  input  logic                two_bit,
  input  logic [9:0]          sw,
  input  logic [9:0]          sh,
  input  logic                wr_en,
  input  logic [10:0]         wr_addr,
  input  logic [7:0]          wr_data,
  input  logic                q_valid,
  input  gbmd_pkg::qcmd_t     q_cmd,
  output logic                q_pop,
  output logic                idle,
  output logic                out_valid,
  output gbmd_pkg::out_item_t out_item
);
  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_DIV  = 6'b000010,
    S_RD   = 6'b000100,
    S_WAIT = 6'b001000,
    S_ACC  = 6'b010000,
    S_OUT  = 6'b100000
  } st_t;

  localparam int unsigned AW = $clog2(STORE_BYTES);

  logic [7:0] mem [STORE_BYTES];
  logic [7:0] rd_r;

  st_t st_r;
  logic [1:0] dstep_r;
  logic [9:0] col_r, row_r;
  logic [8:0] x0_r, x1_r, y0_r, y1_r, sx_r, sy_r;
  logic [1:0] rmax_r;
  logic       oob_r, ov_r;
  logic [1:0] res_r;
  logic       rng_r;
  logic       dgo;
  logic [17:0] dnum, dq;
  logic [9:0]  dden;
  logic        ddone;
  logic [17:0] pos;
  logic [15:0] baddr;
  logic [2:0]  sel_r;
  logic [1:0]  pix;

  // dstep: 0 x0, 1 x1, 2 y0, 3 y1
  always_comb begin
    case (dstep_r)
      2'd0:    begin dnum = 18'(col_r) * 18'(gw); dden = sw; end
      2'd1:    begin dnum = (18'(col_r) + 18'd1) * 18'(gw); dden = sw; end
      2'd2:    begin dnum = 18'(row_r) * 18'(gh); dden = sh; end
      default: begin dnum = (18'(row_r) + 18'd1) * 18'(gh); dden = sh; end
    endcase
  end

  logic dgo_r;
  assign dgo = dgo_r;
  gbmd_divu u_div (
    .clk(clk), .rst_n(rst_n), .go(dgo), .num(dnum), .den(dden),
    .done(ddone), .quo(dq)
  );

  logic [8:0] hi_lim;
  logic [17:0] lo_v;
  always_comb begin
    lo_v = (dstep_r == 2'd1) ? 18'(x0_r) : 18'(y0_r);
    hi_lim = (dstep_r == 2'd1) ? {1'b0, gw} : {1'b0, gh};
  end

  assign pos = 18'(sy_r) * 18'(gw) + 18'(sx_r);
  assign baddr = two_bit ? pos[17:2] : 16'(pos[17:3]);

  always_ff @(posedge clk) begin
    if (wr_en) mem[AW'(wr_addr)] <= wr_data;
    rd_r <= mem[AW'(baddr)];
  end

  always_comb begin
    if (two_bit) begin
      case (sel_r[1:0])
        2'd0:    pix = rd_r[7:6];
        2'd1:    pix = rd_r[5:4];
        2'd2:    pix = rd_r[3:2];
        default: pix = rd_r[1:0];
      endcase
    end else begin
      pix = rd_r[3'd7 - sel_r] ? 2'd3 : 2'd0;
    end
    if (oob_r) pix = 2'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; dgo_r <= 1'b0;
    end else begin
      ov_r <= 1'b0;
      dgo_r <= 1'b0;
      case (st_r)
        S_IDLE: if (q_valid) begin
          col_r <= q_cmd.col; row_r <= q_cmd.row; rng_r <= q_cmd.in_range;
          rmax_r <= 2'd0; dstep_r <= 2'd0;
          if (q_cmd.in_range) begin st_r <= S_DIV; dgo_r <= 1'b1; end
          else st_r <= S_OUT;
        end
        S_DIV: if (ddone) begin
          logic [17:0] hv;
          hv = dq;
          case (dstep_r)
            2'd0, 2'd2: begin
              if (dstep_r == 2'd0) x0_r <= dq[8:0]; else y0_r <= dq[8:0];
            end
            default: begin
              if (hv <= lo_v) hv = lo_v + 18'd1;
              if (hv > 18'(hi_lim)) hv = 18'(hi_lim);
              if (dstep_r == 2'd1) x1_r <= hv[8:0]; else y1_r <= hv[8:0];
            end
          endcase
          dstep_r <= dstep_r + 2'd1;
          if (dstep_r == 2'd3) begin
            sx_r <= x0_r; sy_r <= y0_r; st_r <= S_RD;
          end else dgo_r <= 1'b1;
        end
        S_RD: begin
          if (sy_r >= y1_r || x0_r >= x1_r) st_r <= S_OUT;
          else begin
            oob_r <= {1'b0, baddr} >= 17'(STORE_BYTES);
            sel_r <= two_bit ? {1'b0, pos[1:0]} : pos[2:0];
            st_r <= S_WAIT;
          end
        end
        S_WAIT: st_r <= S_ACC;
        S_ACC: begin
          if (pix > rmax_r) rmax_r <= pix;
          if (sx_r + 9'd1 >= x1_r) begin sx_r <= x0_r; sy_r <= sy_r + 9'd1; end
          else sx_r <= sx_r + 9'd1;
          st_r <= S_RD;
        end
        S_OUT: begin
          ov_r <= 1'b1;
          res_r <= rng_r ? rmax_r : 2'd0;
          st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign q_pop = (st_r == S_IDLE) && q_valid;
  assign idle = (st_r == S_IDLE);
  assign out_valid = ov_r;
  assign out_item.raw_max = res_r;
  assign out_item.inverted_level = 2'd3 - res_r;
  assign out_item.image_level = gbmd_pkg::level_map(2'd3 - res_r);
  assign out_item.ink = res_r != 2'd0;
  assign out_item.in_range = rng_r;
endmodule

[hdl/gbmd_queue.sv]
// ----------------------------------------------------------------------------
// gbmd_queue
// Two-entry command queue between the front and back parts.
// ----------------------------------------------------------------------------
module gbmd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  gbmd_pkg::qcmd_t   din,
  input  logic              pop,
  output logic              valid,
  output logic              full,
  output gbmd_pkg::qcmd_t   dout
);
  gbmd_pkg::qcmd_t ent_r [2];
  logic wp_r, rp_r;
  logic [1:0] cnt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
    end
    if (push) ent_r[wp_r] <= din;
  end

  assign valid = cnt_r != 2'd0;
  assign full = cnt_r[1];
  assign dout = ent_r[rp_r];
endmodule

[hdl/glyph_box_max_downscaler.sv]
// ----------------------------------------------------------------------------
// glyph_box_max_downscaler
// Scales a packed glyph bitmap; one query returns the max level of a box.
// ----------------------------------------------------------------------------
// channel | ports                       | transfer
// in      | start, busy, in_item        | start && !busy
// out     | out_valid, out_item         | out_valid (one cycle)
// cfg     | cfg_we, cfg_index, cfg_data | cfg_we
// A load writes the store when it transfers. An in-range query's result
// follows four divisions (x0, x1, y0, y1), then one store read per box pixel;
// an out-of-range query skips both. Busy is high while two queries wait, while
// the scaled sizes are recomputed after a config write, and for a load while
// any query is still pending. Reset is synchronous; the store is not cleared.
// The receiver cannot stall.
// ----------------------------------------------------------------------------
module glyph_box_max_downscaler #(
  parameter int unsigned STORE_BYTES = 2048
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  output logic                busy,
  input  gbmd_pkg::in_item_t  in_item,
  output logic                out_valid,
  output gbmd_pkg::out_item_t out_item,
  input  logic                cfg_we,
  input  logic [1:0]          cfg_index,
  input  logic [7:0]          cfg_data
);
  logic [7:0] gw, gh;
  logic tb;
  logic [9:0] sw, sh;
  logic wr_en;
  logic [10:0] wr_addr;
  logic [7:0] wr_data;
  logic q_push, q_pop, q_valid, q_full, idle, sz_busy;
  gbmd_pkg::qcmd_t q_in, q_out;
  logic acc;
  logic load_hold;

  // a load waits until every earlier query has read the store
  assign load_hold = (in_item.func == gbmd_pkg::FUNC_LOAD) && (q_valid || !idle);
  assign busy = q_full || sz_busy || load_hold;
  assign acc = start && !busy;

  gbmd_front #(.STORE_BYTES(STORE_BYTES)) u_front (
    .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .acc(acc), .item(in_item), .gw(gw), .gh(gh),
    .two_bit(tb), .sw(sw), .sh(sh), .wr_en(wr_en), .wr_addr(wr_addr),
    .wr_data(wr_data), .q_push(q_push), .q_cmd(q_in), .sz_busy(sz_busy)
  );

  gbmd_queue u_q (
    .clk(clk), .rst_n(rst_n), .push(q_push), .din(q_in), .pop(q_pop),
    .valid(q_valid), .full(q_full), .dout(q_out)
  );

  gbmd_back #(.STORE_BYTES(STORE_BYTES)) u_back (
    .clk(clk), .rst_n(rst_n), .gw(gw), .gh(gh), .two_bit(tb), .sw(sw),
    .sh(sh), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
    .q_valid(q_valid), .q_cmd(q_out), .q_pop(q_pop), .idle(idle),
    .out_valid(out_valid), .out_item(out_item)
  );
endmodule

[hdl/gbmd_checker.sv]
// ----------------------------------------------------------------------------
// gbmd_checker
// Port-level checks for the glyph box max downscaler.
// ----------------------------------------------------------------------------
module gbmd_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input gbmd_pkg::out_item_t out_item
);
  a_inv: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.inverted_level == 2'd3 - out_item.raw_max)
    else $error("inverted level mismatch");
  a_ink: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_item.ink == (out_item.raw_max != 2'd0))
    else $error("ink mismatch");
  a_oor: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.in_range) |-> out_item.raw_max == 2'd0)
    else $error("out of range result not blank");
  a_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");
  a_busy_known: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> !$isunknown(busy))
    else $error("busy unknown during start");
endmodule

bind glyph_box_max_downscaler gbmd_checker u_chk (
  .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
  .out_valid(out_valid), .out_item(out_item)
);

[sim/glyph_box_max_downscaler_tb.sv]
// ----------------------------------------------------------------------------
// glyph_box_max_downscaler_tb
// Fills the bitmap store, then runs directed and random loads and pixel
// queries under a series of glyph sizes, scales and pixel modes. A local
// box-max model predicts every query result; the monitor compares each result
// strobe with its prediction as a whole, in order.
// ----------------------------------------------------------------------------
module glyph_box_max_downscaler_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBYTES = 256;
  localparam int unsigned WDOG_LIMIT = 20000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  gbmd_pkg::in_item_t in_item = '0;
  logic out_valid;
  gbmd_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = '0;
  logic [7:0] cfg_data = '0;

  glyph_box_max_downscaler #(.STORE_BYTES(NBYTES)) dut (
    .clk, .rst_n, .start, .busy, .in_item, .out_valid, .out_item,
    .cfg_we, .cfg_index, .cfg_data
  );

  always #10 clk = ~clk;

  // bitmap model
  logic [7:0] bitmap_mdl [NBYTES];
  int unsigned gw = 8, gh = 8, pct = 100, two_bit = 0;
  int unsigned sw = 8, sh = 8;

  gbmd_pkg::in_item_t pend_q[$];
  gbmd_pkg::out_item_t pixel_q[$];
  int errs = 0;
  int gap = 0;
  bit no_idle = 0;
  int wdog = 0;

  function automatic int unsigned scaled_size(int unsigned size);
    int unsigned v;
    v = (size * pct + 50) / 100;
    if (v < 1) v = 1;
    return v & 10'h3FF;
  endfunction

  function automatic int unsigned pixel_level(int unsigned pos);
    int unsigned a;
    logic [7:0] b;
    a = two_bit ? (pos >> 2) : (pos >> 3);
    b = (a < NBYTES) ? bitmap_mdl[a] : 8'h00;
    if (two_bit) return (b >> ((3 - (pos & 3)) * 2)) & 3;
    return b[7 - (pos & 7)] ? 3 : 0;
  endfunction

  function automatic gbmd_pkg::out_item_t box_max(gbmd_pkg::in_item_t it);
    gbmd_pkg::out_item_t r;
    int unsigned x0, x1, y0, y1, m, v;
    logic [1:0] inv;
    if (it.out_col >= sw || it.out_row >= sh) begin
      r.raw_max = 2'd0; r.inverted_level = 2'd3; r.image_level = 2'd0;
      r.ink = 1'b0; r.in_range = 1'b0;
      return r;
    end
    x0 = (it.out_col * gw) / sw;
    x1 = ((it.out_col + 1) * gw) / sw;
    if (x1 <= x0) x1 = x0 + 1;
    if (x1 > gw) x1 = gw;
    y0 = (it.out_row * gh) / sh;
    y1 = ((it.out_row + 1) * gh) / sh;
    if (y1 <= y0) y1 = y0 + 1;
    if (y1 > gh) y1 = gh;
    m = 0;
    for (int unsigned y = y0; y < y1; y++)
      for (int unsigned x = x0; x < x1; x++) begin
        v = pixel_level(y * gw + x);
        if (v > m) m = v;
      end
    inv = 2'(3 - m);
    r.raw_max = 2'(m);
    r.inverted_level = inv;
    case (inv)
      2'd0: r.image_level = 2'd3;
      2'd1: r.image_level = 2'd1;
      2'd2: r.image_level = 2'd2;
      default: r.image_level = 2'd0;
    endcase
    r.ink = (m != 0);
    r.in_range = 1'b1;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // driver
  always @(posedge clk) begin
    bit take;
    if (!rst_n) begin
      start <= 1'b0;
    end else begin
      take = 0;
      if (start && !busy) begin
        if (in_item.func == gbmd_pkg::FUNC_LOAD) begin
          if (in_item.byte_addr < NBYTES) bitmap_mdl[in_item.byte_addr] = in_item.byte_data;
        end else begin
          pixel_q.insert(pixel_q.size(), box_max(in_item));
        end
        gap = pick_gap();
        take = (gap == 0);
      end else if (!start) begin
        if (gap > 0) gap--;
        take = (gap == 0);
      end
      if (start && busy) begin
        // hold
      end else if (take && pend_q.size() > 0) begin
        start <= 1'b1;
        in_item <= pend_q.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    gbmd_pkg::out_item_t e;
    if (rst_n && out_valid) begin
      if (pixel_q.size() == 0) begin
        errs++;
        if (errs <= 10) $display("ERROR: unexpected result %p", out_item);
      end else begin
        e = pixel_q.pop_front();
        if (out_item !== e) begin
          errs++;
          if (errs <= 10) $display("ERROR: expected %p got %p", e, out_item);
        end
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((start && !busy) || out_valid || !rst_n) wdog <= 0;
    else wdog <= wdog + 1;
    if (wdog >= WDOG_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  function automatic gbmd_pkg::in_item_t load_item(int unsigned a, int unsigned d);
    gbmd_pkg::in_item_t it;
    it = gbmd_pkg::in_item_t'(40'({$urandom, $urandom}));
    it.func = gbmd_pkg::FUNC_LOAD;
    it.byte_addr = 11'(a);
    it.byte_data = 8'(d);
    return it;
  endfunction

  function automatic gbmd_pkg::in_item_t query_item(int unsigned c, int unsigned r);
    gbmd_pkg::in_item_t it;
    it = gbmd_pkg::in_item_t'(40'({$urandom, $urandom}));
    it.func = gbmd_pkg::FUNC_QUERY;
    it.out_col = 10'(c);
    it.out_row = 10'(r);
    return it;
  endfunction

  function automatic int unsigned pick_coord(int unsigned s);
    int r;
    int unsigned v;
    r = $urandom_range(0, 99);
    if (r < 60) return $urandom_range(0, s - 1);
    if (r < 85) begin
      v = s - 1 + $urandom_range(0, 2);
      return (v > 1023) ? 1023 : v;
    end
    return $urandom_range(0, 1023);
  endfunction

  task automatic drain();
    while (pend_q.size() != 0 || start || pixel_q.size() != 0) @(posedge clk);
    repeat (150) @(posedge clk);
  endtask

  task automatic cfg_write(gbmd_pkg::cfg_idx_t idx, int unsigned val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= 8'(val);
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      gbmd_pkg::CFG_GLYPH_WIDTH:  gw = val & 8'hFF;
      gbmd_pkg::CFG_GLYPH_HEIGHT: gh = val & 8'hFF;
      gbmd_pkg::CFG_SCALE_PCT:    pct = val & 8'hFF;
      default:                    two_bit = val & 1;
    endcase
    sw = scaled_size(gw);
    sh = scaled_size(gh);
    @(posedge clk);
    while (busy) @(posedge clk);
  endtask

  task automatic run_phase(int unsigned w, int unsigned h, int unsigned p,
                           int unsigned m, int n);
    drain();
    cfg_write(gbmd_pkg::CFG_GLYPH_WIDTH, w);
    cfg_write(gbmd_pkg::CFG_GLYPH_HEIGHT, h);
    cfg_write(gbmd_pkg::CFG_SCALE_PCT, p);
    cfg_write(gbmd_pkg::CFG_TWO_BIT_MODE, m);
    no_idle = ($urandom_range(0, 3) == 0);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 99) < 30)
        pend_q.insert(pend_q.size(), load_item($urandom_range(0, 2047), $urandom));
      else
        pend_q.insert(pend_q.size(), query_item(pick_coord(sw), pick_coord(sh)));
    end
  endtask

  initial begin
    int unsigned w, h;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    // fill the whole store so no query touches an unwritten byte
    for (int unsigned a = 0; a < NBYTES; a++)
      pend_q.insert(pend_q.size(), load_item(a, $urandom));
    drain();
    pend_q.insert(pend_q.size(), load_item(0, 8'hFF));
    pend_q.insert(pend_q.size(), load_item(NBYTES - 1, 8'h00));
    pend_q.insert(pend_q.size(), load_item(7, 8'hAA));
    pend_q.insert(pend_q.size(), query_item(0, 0));
    pend_q.insert(pend_q.size(), query_item(7, 7));
    pend_q.insert(pend_q.size(), query_item(8, 0));
    pend_q.insert(pend_q.size(), query_item(0, 8));
    pend_q.insert(pend_q.size(), query_item(1023, 1023));
    pend_q.insert(pend_q.size(), query_item(3, 1023));
    pend_q.insert(pend_q.size(), query_item(1023, 3));
    pend_q.insert(pend_q.size(), query_item(7, 0));
    pend_q.insert(pend_q.size(), query_item(0, 7));
    run_phase(255, 255, 255, 1, 60);
    run_phase(255, 4, 0, 0, 6);
    run_phase(1, 1, 0, 1, 40);
    run_phase(1, 255, 50, 0, 60);
    run_phase(16, 16, 255, 1, 60);
    for (int k = 0; k < 4; k++) begin
      w = $urandom_range(1, 20);
      h = $urandom_range(1, 20);
      run_phase(w, h, $urandom_range(0, 255), $urandom_range(0, 1), 75);
    end
    drain();
    if (errs == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
